>>> sv/pfr_pkg.sv
// Shared types, codes and constants for the pixel framebuffer page refresh block.
package pfr_pkg;

	localparam logic [2:0] MODE_SET    = 3'd0;
	localparam logic [2:0] MODE_CLR    = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_WIPE   = 3'd3;
	localparam logic [2:0] MODE_STREAM = 3'd4;

	localparam logic [2:0] OP_SET       = 3'd0;
	localparam logic [2:0] OP_CLR       = 3'd1;
	localparam logic [2:0] OP_READ      = 3'd2;
	localparam logic [2:0] OP_READ_ZERO = 3'd3;
	localparam logic [2:0] OP_WIPE      = 3'd4;
	localparam logic [2:0] OP_STREAM    = 3'd5;

	localparam int unsigned HEADER_BYTES  = 7;
	localparam int unsigned HDR_CMD_CTRL  = 0;
	localparam int unsigned HDR_PAGE      = 1;
	localparam int unsigned HDR_COL_LO    = 2;
	localparam int unsigned HDR_COL_HI    = 3;
	localparam int unsigned HDR_DATA_CTRL = 4;
	localparam int unsigned BITMAP_PAGES  = 8;

	localparam logic [7:0] CMD_CTRL_BYTE  = 8'h00;
	localparam logic [7:0] PAGE_CMD_BYTE  = 8'hb0;
	localparam logic [7:0] COL_LO_BYTE    = 8'h00;
	localparam logic [7:0] COL_HI_BYTE    = 8'h10;
	localparam logic [7:0] DATA_CTRL_BYTE = 8'h40;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd60;

	typedef struct packed {
		logic [2:0] mode;
		logic [5:0] column;
		logic [4:0] row;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic       pixel_value;
		logic [7:0] out_byte;
		logic       frame_first;
		logic       frame_last;
		logic       refresh_last;
		logic [6:0] target_address;
	} rsp_t;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] column;
		logic [4:0] row;
	} cmd_t;

	function automatic logic [7:0] dbl_nibble(input logic [3:0] n);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			r[2*i]   = n[i];
			r[2*i+1] = n[i];
		end
		return r;
	endfunction

endpackage

>>> sv/pfr_front.sv
// Front end: accepts items, drops no-op items, classifies the rest into commands.
module pfr_front import pfr_pkg::*; #(
	parameter int SOURCE_COLUMNS = 64
) (
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	input  logic q_full,
	output logic q_push,
	output cmd_t q_cmd
);

	localparam logic [9:0] SRC_LIM = 10'(SOURCE_COLUMNS);

	logic col_ok;
	logic keep;

	always_comb begin
		col_ok = 10'(req.column) < SRC_LIM;
		keep = 1'b1;
		q_cmd.column = req.column;
		q_cmd.row = req.row;
		q_cmd.op = OP_STREAM;
		case (req.mode)
			MODE_SET: begin
				q_cmd.op = OP_SET;
				keep = col_ok;
			end
			MODE_CLR: begin
				q_cmd.op = OP_CLR;
				keep = col_ok;
			end
			MODE_READ: begin
				q_cmd.op = col_ok ? OP_READ : OP_READ_ZERO;
			end
			MODE_WIPE: begin
				q_cmd.op = OP_WIPE;
			end
			MODE_STREAM: begin
				q_cmd.op = OP_STREAM;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_ready = !q_full;
	assign q_push = req_valid && !q_full && keep;

endmodule

>>> sv/pfr_queue.sv
// Two-entry command queue between the front and back ends.
module pfr_queue import pfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = entries_q[rd_ptr_q];

endmodule

>>> sv/pfr_back.sv
// Back end: bitmap memory, refresh stream counters and result register.
module pfr_back import pfr_pkg::*; #(
	parameter int SOURCE_COLUMNS = 64,
	parameter int PAGE_COUNT = 8,
	parameter int PANEL_COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	input  logic [6:0] dev_addr,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	localparam int SRC_W = $clog2(SOURCE_COLUMNS);
	localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int LAST_POS = HEADER_BYTES + PANEL_COLUMNS - 1;
	localparam int POS_W = $clog2(LAST_POS + 1);

	logic [31:0]         mem_q [SOURCE_COLUMNS];
	logic [SOURCE_COLUMNS-1:0] vld_q;
	logic [POS_W-1:0]    pos_q;
	logic [PAGE_W-1:0]   page_q;
	logic                s1_vld_q;
	logic [2:0]          op_s1;
	logic [SRC_W-1:0]    addr_s1;
	logic [4:0]          row_s1;
	logic [31:0]         rdata_s1;
	logic                rvld_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [9:0]       pos_x;
	logic [9:0]       col_idx;
	logic [9:0]       src_x;
	logic [9:0]       colx;
	logic             in_map;
	logic [SRC_W-1:0] rd_addr;
	logic [31:0]      word;
	logic [5:0]       sh;
	logic [3:0]       nib;
	logic [7:0]       sbyte;
	logic             first;
	logic             flast;
	logic             rlast;
	logic             emits;
	logic             done_b;
	logic             wr_en;
	logic [31:0]      wdata;
	rsp_t             rsp_c;

	always_comb begin
		pos_x = 10'(pos_q);
		col_idx = pos_x - 10'(HEADER_BYTES);
		src_x = {1'b0, col_idx[9:1]};
		in_map = (pos_x >= 10'(HEADER_BYTES)) && (src_x < 10'(SOURCE_COLUMNS))
			&& (5'(page_q) < 5'(BITMAP_PAGES));
		colx = 10'(q_head.column);
		rd_addr = (q_head.op == OP_STREAM) ? src_x[SRC_W-1:0] : colx[SRC_W-1:0];
		q_pop = !q_empty && !s1_vld_q;
	end

	always_comb begin
		word = rvld_s1 ? rdata_s1 : '0;
		sh = 6'(page_q) << 2;
		nib = 4'(word >> sh);
		if (pos_x == 10'(HDR_CMD_CTRL))
			sbyte = CMD_CTRL_BYTE;
		else if (pos_x == 10'(HDR_PAGE))
			sbyte = PAGE_CMD_BYTE | 8'(page_q);
		else if (pos_x == 10'(HDR_COL_LO))
			sbyte = COL_LO_BYTE;
		else if (pos_x == 10'(HDR_COL_HI))
			sbyte = COL_HI_BYTE;
		else if (pos_x == 10'(HDR_DATA_CTRL))
			sbyte = DATA_CTRL_BYTE;
		else if (in_map)
			sbyte = dbl_nibble(nib);
		else
			sbyte = 8'h00;
		first = (pos_x == 10'(HDR_CMD_CTRL)) || (pos_x == 10'(HDR_DATA_CTRL));
		flast = (pos_x == 10'(HDR_COL_HI)) || (pos_q == POS_W'(LAST_POS));
		rlast = (pos_q == POS_W'(LAST_POS)) && (page_q == PAGE_W'(PAGE_COUNT - 1));

		rsp_c = '0;
		if (op_s1 == OP_STREAM) begin
			rsp_c.result_kind = 1'b1;
			rsp_c.out_byte = sbyte;
			rsp_c.frame_first = first;
			rsp_c.frame_last = flast;
			rsp_c.refresh_last = rlast;
			rsp_c.target_address = first ? dev_addr : 7'd0;
		end else begin
			rsp_c.pixel_value = (op_s1 == OP_READ) ? word[row_s1] : 1'b0;
		end

		emits = (op_s1 == OP_READ) || (op_s1 == OP_READ_ZERO) || (op_s1 == OP_STREAM);
		done_b = s1_vld_q && (!emits || !rsp_valid_q || rsp_ready);
		wr_en = done_b && ((op_s1 == OP_SET) || (op_s1 == OP_CLR));
		if (op_s1 == OP_SET)
			wdata = word | (32'd1 << row_s1);
		else
			wdata = word & ~(32'd1 << row_s1);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_s1 <= mem_q[rd_addr];
			op_s1 <= q_head.op;
			addr_s1 <= colx[SRC_W-1:0];
			row_s1 <= q_head.row;
		end
		if (wr_en)
			mem_q[addr_s1] <= wdata;
		if (done_b && emits)
			rsp_q <= rsp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
			s1_vld_q <= 1'b0;
			pos_q <= '0;
			page_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				rvld_s1 <= vld_q[rd_addr];
				s1_vld_q <= 1'b1;
			end else if (done_b) begin
				s1_vld_q <= 1'b0;
			end
			if (wr_en)
				vld_q[addr_s1] <= 1'b1;
			else if (done_b && op_s1 == OP_WIPE)
				vld_q <= '0;
			if (done_b && op_s1 == OP_STREAM) begin
				if (pos_q == POS_W'(LAST_POS)) begin
					pos_q <= '0;
					page_q <= (page_q == PAGE_W'(PAGE_COUNT - 1)) ? '0
						: page_q + PAGE_W'(1);
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (done_b && emits)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> sv/pixel_framebuffer_page_refresh_top.sv
// Top level of the pixel framebuffer with page-mode refresh stream.
// Items enter a two-entry command queue as long as it has room; the back end
// then handles each command in two steps, one to read the bitmap word and one
// to write it back or load the result register, and pops the next command
// only once the last one has finished its second step. Items that do nothing
// (unused modes, out-of-range set or clear) are accepted while the queue has
// room and never reach the queue. Clearing the bitmap drops every per-column
// valid flag at once; there is no clearing pass after reset.
// A result waits in an output register, and the back end keeps working until
// it needs that register again.
module pixel_framebuffer_page_refresh_top import pfr_pkg::*; #(
	parameter int SOURCE_COLUMNS = 64,
	parameter int PAGE_COUNT = 8,
	parameter int PANEL_COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	logic [6:0] dev_addr_q;
	logic       q_full;
	logic       q_push;
	cmd_t       q_cmd;
	logic       q_pop;
	cmd_t       q_head;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dev_addr_q <= DEV_ADDR_RESET;
		else if (cfg_we)
			dev_addr_q <= cfg_wdata;
	end

	pfr_front #(
		.SOURCE_COLUMNS(SOURCE_COLUMNS)
	) u_front (
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	pfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	pfr_back #(
		.SOURCE_COLUMNS(SOURCE_COLUMNS),
		.PAGE_COUNT(PAGE_COUNT),
		.PANEL_COLUMNS(PANEL_COLUMNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.dev_addr(dev_addr_q),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

>>> sv/pfr_checker.sv
// Port-level checker for the framebuffer refresh block, with its bind.
module pfr_checker import pfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("input item changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.result_kind |-> rsp.out_byte == 8'h00 && !rsp.frame_first
			&& !rsp.frame_last && !rsp.refresh_last && rsp.target_address == 7'd0)
		else $error("pixel reply carries stream fields");

	a_addr_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.frame_first |-> rsp.target_address == 7'd0)
		else $error("bus address outside frame start");

	a_refresh_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.refresh_last |-> rsp.frame_last && rsp.result_kind
			&& !rsp.frame_first && !rsp.pixel_value)
		else $error("refresh end not on a closing stream byte");

endmodule

bind pixel_framebuffer_page_refresh_top pfr_checker u_pfr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);

>>> tb/tb.sv
// Testbench for the pixel framebuffer page refresh block: random traffic checked by a predictor.
module tb;
	import pfr_pkg::*;

	localparam int unsigned SRC_COLS = 64;
	localparam int unsigned PAGES = 8;
	localparam int unsigned PANEL_COLS = 128;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	class framebuffer_scoreboard;
		logic [31:0] bitmap [SRC_COLS];
		int unsigned page;
		int unsigned position;
		logic [6:0] address;
		rsp_t awaited_results [$];
		int unsigned failures;

		function new();
			foreach (bitmap[c]) bitmap[c] = '0;
			page = 0;
			position = 0;
			address = DEV_ADDR_RESET;
			failures = 0;
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int unsigned last_pos;
			int unsigned src;
			int unsigned shift;
			logic [3:0] nib;
			e = '0;
			last_pos = HEADER_BYTES + PANEL_COLS - 1;
			case (r.mode)
				MODE_SET: begin
					if (r.column < SRC_COLS) bitmap[r.column][r.row] = 1'b1;
				end
				MODE_CLR: begin
					if (r.column < SRC_COLS) bitmap[r.column][r.row] = 1'b0;
				end
				MODE_READ: begin
					e.pixel_value = (r.column < SRC_COLS) ? bitmap[r.column][r.row] : 1'b0;
					awaited_results.push_back(e);
				end
				MODE_WIPE: begin
					foreach (bitmap[c]) bitmap[c] = '0;
				end
				MODE_STREAM: begin
					e.result_kind = 1'b1;
					e.frame_first = (position == HDR_CMD_CTRL) || (position == HDR_DATA_CTRL);
					e.frame_last = (position == HDR_COL_HI) || (position == last_pos);
					e.refresh_last = (position == last_pos) && (page == PAGES - 1);
					e.target_address = e.frame_first ? address : 7'd0;
					if (position == HDR_CMD_CTRL) e.out_byte = CMD_CTRL_BYTE;
					else if (position == HDR_PAGE) e.out_byte = PAGE_CMD_BYTE | 8'(page);
					else if (position == HDR_COL_LO) e.out_byte = COL_LO_BYTE;
					else if (position == HDR_COL_HI) e.out_byte = COL_HI_BYTE;
					else if (position == HDR_DATA_CTRL) e.out_byte = DATA_CTRL_BYTE;
					else if (position < HEADER_BYTES) e.out_byte = 8'h00;
					else begin
						src = (position - HEADER_BYTES) / 2;
						shift = page * 4;
						if (src < SRC_COLS && shift < 32) begin
							nib = 4'(bitmap[src] >> shift);
							// each source row covers two panel rows
							for (int i = 0; i < 4; i++) begin
								e.out_byte[2*i] = nib[i];
								e.out_byte[2*i+1] = nib[i];
							end
						end
					end
					awaited_results.push_back(e);
					if (position >= last_pos) begin
						position = 0;
						page = (page + 1 >= PAGES) ? 0 : page + 1;
					end else begin
						position++;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_field(string name, logic [7:0] expected, logic [7:0] actual);
			if (actual !== expected) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
				failures++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (awaited_results.size() == 0) begin
				$error("result item with nothing expected: %p", got);
				failures++;
				return;
			end
			e = awaited_results.pop_front();
			check_field("result_kind", e.result_kind, got.result_kind);
			check_field("pixel_value", e.pixel_value, got.pixel_value);
			check_field("out_byte", e.out_byte, got.out_byte);
			check_field("frame_first", e.frame_first, got.frame_first);
			check_field("frame_last", e.frame_last, got.frame_last);
			check_field("refresh_last", e.refresh_last, got.refresh_last);
			check_field("target_address", e.target_address, got.target_address);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	framebuffer_scoreboard sb = new();
	int unsigned burst_left = 0;
	req_t recent_pixel = '0;
	logic [31:0] ready_pattern = '1;
	logic [5:0] stall_tick = '0;
	int unsigned idle_cycles = 0;

	pixel_framebuffer_page_refresh_top #(
		.SOURCE_COLUMNS(SRC_COLS),
		.PAGE_COUNT(PAGES),
		.PANEL_COLUMNS(PANEL_COLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == '0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= '1;
				1: ready_pattern <= $urandom | 32'h1;
				2: ready_pattern <= ($urandom & $urandom) | 32'h8000_0001;
				default: ready_pattern <= $urandom | $urandom;
			endcase
		end else begin
			ready_pattern <= {ready_pattern[30:0], ready_pattern[31]};
		end
		rsp_ready <= ready_pattern[31];
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[pixel_framebuffer_page_refresh_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(input req_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(item);
	endtask

	task automatic send_op(input logic [2:0] mode, input logic [5:0] column,
			input logic [4:0] row);
		req_t item;
		item.mode = mode;
		item.column = column;
		item.row = row;
		send_item(item);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_address(input logic [6:0] value);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.address = value;
	endtask

	// weights in permille; the remainder goes to unused modes
	task automatic run_phase(input int unsigned count, input int unsigned w_set,
			input int unsigned w_clr, input int unsigned w_read,
			input int unsigned w_wipe, input int unsigned w_stream);
		req_t item;
		int unsigned pick;
		repeat (count) begin
			item.column = $urandom_range(0, 63);
			item.row = $urandom_range(0, 31);
			pick = $urandom_range(0, 999);
			if (pick < w_set) begin
				item.mode = MODE_SET;
				recent_pixel = item;
			end else if (pick < w_set + w_clr) begin
				item.mode = MODE_CLR;
				if ($urandom_range(0, 1)) {item.column, item.row} =
					{recent_pixel.column, recent_pixel.row};
			end else if (pick < w_set + w_clr + w_read) begin
				item.mode = MODE_READ;
				if ($urandom_range(0, 1)) {item.column, item.row} =
					{recent_pixel.column, recent_pixel.row};
			end else if (pick < w_set + w_clr + w_read + w_wipe) begin
				item.mode = MODE_WIPE;
			end else if (pick < w_set + w_clr + w_read + w_wipe + w_stream) begin
				item.mode = MODE_STREAM;
			end else begin
				item.mode = 3'($urandom_range(5, 7));
			end
			send_item(item);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset address on the first frame start, pixel corners, unused modes, wipe
		send_op(MODE_STREAM, 6'd0, 5'd0);
		send_op(MODE_SET, 6'd0, 5'd0);
		send_op(MODE_SET, 6'd63, 5'd31);
		send_op(MODE_SET, 6'd0, 5'd31);
		send_op(MODE_CLR, 6'd5, 5'd5);
		send_op(MODE_READ, 6'd0, 5'd0);
		send_op(MODE_READ, 6'd63, 5'd31);
		send_op(MODE_READ, 6'd1, 5'd1);
		send_op(MODE_CLR, 6'd63, 5'd31);
		send_op(MODE_READ, 6'd63, 5'd31);
		send_op(3'd5, 6'd63, 5'd31);
		send_op(3'd6, 6'd42, 5'd21);
		send_op(3'd7, 6'd21, 5'd10);
		send_op(MODE_WIPE, 6'd0, 5'd0);
		send_op(MODE_READ, 6'd0, 5'd0);
		send_op(MODE_SET, 6'd0, 5'd2);
		send_op(MODE_SET, 6'd1, 5'd1);
		repeat (8) send_op(MODE_STREAM, 6'd63, 5'd31);

		set_address(7'd127);
		run_phase(250, 550, 100, 200, 0, 100);
		set_address(7'd0);
		run_phase(750, 80, 20, 40, 0, 850);
		set_address(7'($urandom_range(1, 126)));
		run_phase(350, 250, 100, 200, 20, 380);
		set_address(7'($urandom_range(0, 127)));
		run_phase(600, 80, 20, 40, 5, 850);

		wait_quiet();
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("[pixel_framebuffer_page_refresh_top] OK");
		end else begin
			$display("[pixel_framebuffer_page_refresh_top] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
sv/pfr_pkg.sv
sv/pfr_front.sv
sv/pfr_queue.sv
sv/pfr_back.sv
sv/pixel_framebuffer_page_refresh_top.sv
sv/pfr_checker.sv
tb/tb.sv
